// ===== rtl/core/utf8_identifier_validator_top_macros.svh =====
// ---------------------------------------------------------------------------
// utf8 identifier validator assertion macros
// shared concurrent assertion forms for the validator rtl
// ---------------------------------------------------------------------------
`ifndef UTF8_IDENTIFIER_VALIDATOR_TOP_MACROS_SVH
`define UTF8_IDENTIFIER_VALIDATOR_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define UTF8IV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("utf8iv assertion failed");

// next-cycle implication, disabled during reset
`define UTF8IV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("utf8iv assertion failed");

`endif

// ===== rtl/core/utf8iv_pkg.sv =====
// ---------------------------------------------------------------------------
// utf8iv_pkg
// status codes, sequence state type and byte constants for the validator
// ---------------------------------------------------------------------------
package utf8iv_pkg;

    typedef enum logic [2:0] {
        ST_VALID     = 3'd0,
        ST_BAD_LEAD  = 3'd1,
        ST_TRUNCATED = 3'd2,
        ST_BAD_CONT  = 3'd3,
        ST_OVERLONG  = 3'd4,
        ST_SURROGATE = 3'd5,
        ST_TOO_LARGE = 3'd6
    } t_status;

    typedef struct packed {
        t_status    held_error;
        t_status    seq_error;
        logic [1:0] remaining;
        logic [7:0] lead;
        logic       expect_second;
    } t_seq_state;

    localparam logic [7:0] C_MSB_MASK   = 8'h80;
    localparam logic [7:0] C_MASK_E0    = 8'hE0;
    localparam logic [7:0] C_MASK_C0    = 8'hC0;
    localparam logic [7:0] C_MASK_F0    = 8'hF0;
    localparam logic [7:0] C_MASK_F8    = 8'hF8;
    localparam logic [7:0] C_MIN_LEAD2  = 8'hC2;
    localparam logic [7:0] C_MIN_E0_2ND = 8'hA0;
    localparam logic [7:0] C_LEAD_ED    = 8'hED;
    localparam logic [7:0] C_MIN_F0_2ND = 8'h90;
    localparam logic [7:0] C_MAX_LEAD4  = 8'hF4;
    localparam logic [7:0] C_MAX_F4_2ND = 8'h8F;

    // sequence length from a lead byte, zero for a continuation byte or 8'hF8-8'hFF
    function automatic logic [2:0] seq_len(input logic [7:0] b);
        if ((b & C_MSB_MASK) == 8'h00) begin
            return 3'd1;
        end else if ((b & C_MASK_E0) == C_MASK_C0) begin
            return 3'd2;
        end else if ((b & C_MASK_F0) == C_MASK_E0) begin
            return 3'd3;
        end else if ((b & C_MASK_F8) == C_MASK_F0) begin
            return 3'd4;
        end
        return 3'd0;
    endfunction

endpackage

// ===== rtl/core/utf8_identifier_validator_top.sv =====
// ---------------------------------------------------------------------------
// utf8_identifier_validator_top
// streaming utf-8 checker for identifier spellings, one status per identifier
// ---------------------------------------------------------------------------
// Takes one byte of an identifier per cycle on the slave stream, tlast on the
// final byte, and returns one status on the master stream for each identifier:
// 0 valid, 1 bad lead, 2 truncated, 3 bad continuation, 4 overlong,
// 5 surrogate, 6 above U+10FFFF. The first failing sequence is the one
// reported. Throughput is one byte per cycle while no final byte waits; the
// final byte is caught in the input register, then its status in the result
// register, and the per-byte check with its sequence state update is
// combinational logic. A final byte waits in the input register only while
// the result register holds a status not yet taken.
`include "utf8_identifier_validator_top_macros.svh"

module utf8_identifier_validator_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  logic       s_axis_tlast,   // final_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [2:0] check_status, [7:3] zero
);
    import utf8iv_pkg::*;

    logic       r_in_valid;
    logic       n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    t_seq_state r_state;
    t_seq_state n_state;
    t_status    w_status;
    logic       w_out_free;
    logic       w_advance;
    logic       w_take;

    assign w_advance     = r_in_valid && (!r_in_last || w_out_free);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_take        = s_axis_tvalid && s_axis_tready;
    assign n_in_valid    = w_take || (r_in_valid && !w_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
        end else begin
            r_in_valid <= n_in_valid;
            if (w_advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    utf8iv_step u_step (
        .i_state      (r_state),
        .i_byte       (r_in_byte),
        .i_last       (r_in_last),
        .o_next_state (n_state),
        .o_status     (w_status)
    );

    utf8iv_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_advance && r_in_last),
        .i_status      (w_status),
        .o_free        (w_out_free),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata)
    );

    // an open sequence always has a multi-byte lead stored
    `UTF8IV_ASSERT_NOW(a_open_lead, i_clk, i_rst_n,
        r_state.remaining != 2'd0, r_state.lead[7:6] == 2'b11)
    // a held error never coexists with an open sequence
    `UTF8IV_ASSERT_NOW(a_held_closed, i_clk, i_rst_n,
        r_state.held_error != ST_VALID, r_state.remaining == 2'd0)
    // the final byte returns the sequence state to idle
    `UTF8IV_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n,
        w_advance && r_in_last, r_state == t_seq_state'('0))
    // status codes stay in range and padding stays zero
    `UTF8IV_ASSERT_NOW(a_status_range, i_clk, i_rst_n,
        m_axis_tvalid, m_axis_tdata[7:3] == 5'd0 && m_axis_tdata[2:0] != 3'd7)

endmodule

// ===== rtl/core/utf8iv_step.sv =====
// ---------------------------------------------------------------------------
// utf8iv_step
// per-byte decode and check: next sequence state and end-of-identifier status
// ---------------------------------------------------------------------------
module utf8iv_step (
    input  utf8iv_pkg::t_seq_state i_state,
    input  logic [7:0]             i_byte,
    input  logic                   i_last,
    output utf8iv_pkg::t_seq_state o_next_state,
    output utf8iv_pkg::t_status    o_status
);
    import utf8iv_pkg::*;

    t_seq_state s;
    logic [2:0] len_lead;
    logic [2:0] len_open;
    logic [2:0] len_less;

    assign len_lead = seq_len(i_byte);
    assign len_open = seq_len(i_state.lead);
    assign len_less = len_lead - 3'd1;

    always_comb begin
        s = i_state;
        if (i_state.held_error == ST_VALID) begin
            if (i_state.remaining == 2'd0) begin
                if (len_lead == 3'd0) begin
                    s.held_error = ST_BAD_LEAD;
                end else if (len_lead != 3'd1) begin
                    s.remaining     = len_less[1:0];
                    s.lead          = i_byte;
                    s.expect_second = 1'b1;
                    s.seq_error     = ST_VALID;
                    if (len_lead == 3'd2 && i_byte < C_MIN_LEAD2) begin
                        s.seq_error = ST_OVERLONG;
                    end
                    if (len_lead == 3'd4 && i_byte > C_MAX_LEAD4) begin
                        s.seq_error = ST_TOO_LARGE;
                    end
                end
            end else begin
                if ((i_byte & C_MASK_C0) != C_MSB_MASK) begin
                    s.seq_error = ST_BAD_CONT;
                end else if (i_state.expect_second && i_state.seq_error == ST_VALID) begin
                    if (len_open == 3'd3) begin
                        if (i_state.lead == C_MASK_E0 && i_byte < C_MIN_E0_2ND) begin
                            s.seq_error = ST_OVERLONG;
                        end
                        if (i_state.lead == C_LEAD_ED && i_byte >= C_MIN_E0_2ND) begin
                            s.seq_error = ST_SURROGATE;
                        end
                    end else if (len_open == 3'd4) begin
                        if (i_state.lead == C_MASK_F0 && i_byte < C_MIN_F0_2ND) begin
                            s.seq_error = ST_OVERLONG;
                        end
                        if (i_state.lead == C_MAX_LEAD4 && i_byte > C_MAX_F4_2ND) begin
                            s.seq_error = ST_TOO_LARGE;
                        end
                    end
                end
                s.expect_second = 1'b0;
                s.remaining     = i_state.remaining - 2'd1;
                if (s.remaining == 2'd0) begin
                    s.held_error = s.seq_error;
                end
            end
        end
    end

    always_comb begin
        if (s.held_error != ST_VALID) begin
            o_status = s.held_error;
        end else if (s.remaining != 2'd0) begin
            o_status = ST_TRUNCATED;
        end else begin
            o_status = ST_VALID;
        end
    end

    // identifier done: back to the idle sequence state
    assign o_next_state = i_last ? t_seq_state'('0) : s;

endmodule

// ===== rtl/core/utf8iv_out.sv =====
// ---------------------------------------------------------------------------
// utf8iv_out
// result register for the status stream
// ---------------------------------------------------------------------------
module utf8iv_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  utf8iv_pkg::t_status i_status,
    output logic                o_free,
    input  logic                m_axis_tready,
    output logic                m_axis_tvalid,
    output logic [7:0]          m_axis_tdata   // [2:0] check_status, [7:3] zero
);
    import utf8iv_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_status r_status;

    assign o_free  = !r_valid || m_axis_tready;
    assign n_valid = i_load || (r_valid && !m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_status <= i_status;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {5'b0, r_status};

endmodule
